// ===== sv/quad_outline_point_generator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Outline point generator assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef QUAD_OUTLINE_POINT_GENERATOR_TOP_DEFINES_SVH
`define QUAD_OUTLINE_POINT_GENERATOR_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define QOPG_ASSERT_SAME(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent
`define QOPG_ASSERT_NEXT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/qopg_pkg.sv =====
// ----------------------------------------------------------------------------
// Outline point generator package
// Register map, state encodings and fixed constants of the block.
// ----------------------------------------------------------------------------
package qopg_pkg;

	localparam int COLOR_W      = 24;
	localparam int CORNER_NUM   = 4;
	localparam int CORNER_IDX_W = 2;
	localparam int REG_IDX_W    = 3;

	// reset values of the setup registers
	localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hFF_FFFF;
	localparam int DWELL_RESET = 8;
	localparam int EDGE_RESET  = 32;

	localparam logic [CORNER_IDX_W-1:0] LAST_CORNER = 2'd3;

	// register indexes, byte address is index times the bus width in bytes
	typedef enum logic [REG_IDX_W-1:0] {
		REG_CORNER_ONE,
		REG_CORNER_TWO,
		REG_CORNER_THREE,
		REG_CORNER_FOUR,
		REG_POINT_COLOR,
		REG_DWELL_COUNT,
		REG_EDGE_COUNT
	} reg_idx_t;

	// point sequencer
	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_SKIP,
		SEQ_FETCH_S,
		SEQ_FETCH_E,
		SEQ_START_X,
		SEQ_WAIT_X,
		SEQ_WAIT_Y,
		SEQ_EMIT
	} seq_state_t;

	// multiply/divide unit
	typedef enum logic [2:0] {
		MDU_IDLE,
		MDU_MUL_S,
		MDU_MUL_E,
		MDU_ABS,
		MDU_DIV
	} mdu_state_t;

endpackage

// ===== sv/qopg_chan_if.sv =====
// ----------------------------------------------------------------------------
// Outline point generator channels
// Valid/ready request channel and point result channel.
// ----------------------------------------------------------------------------
interface qopg_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface qopg_point_if #(
	parameter int COORD_WIDTH = 16
);
	logic                            valid;
	logic                            ready;
	logic signed [COORD_WIDTH-1:0]   point_x;
	logic signed [COORD_WIDTH-1:0]   point_y;
	logic [qopg_pkg::COLOR_W-1:0]    out_color;
	logic                            outline_end;

	modport source (output valid, output point_x, output point_y, output out_color,
		output outline_end, input ready);
	modport sink (input valid, input point_x, input point_y, input out_color,
		input outline_end, output ready);
endinterface

// ===== sv/qopg_regs.sv =====
// ----------------------------------------------------------------------------
// Outline point generator register file
// APB setup registers; the four corners sit in a small memory with a
// registered read port for the sequencer and one for the bus.
// ----------------------------------------------------------------------------
module qopg_regs #(
	parameter int COORD_WIDTH = 16,
	parameter int COUNT_WIDTH = 10,
	parameter int DATA_W      = 32,
	parameter int ADDR_W      = 5
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [ADDR_W-1:0]                     paddr,
	input  logic [DATA_W-1:0]                     pwdata,
	output logic [DATA_W-1:0]                     prdata,
	output logic                                  pready,
	input  logic [qopg_pkg::CORNER_IDX_W-1:0]     rd_addr,
	output logic [2*COORD_WIDTH-1:0]              corner_rd,
	output logic [qopg_pkg::COLOR_W-1:0]          point_color,
	output logic [COUNT_WIDTH-1:0]                dwell_count,
	output logic [COUNT_WIDTH-1:0]                edge_count
);

	localparam int CORNER_W = 2 * COORD_WIDTH;
	localparam int ALIGN    = ADDR_W - qopg_pkg::REG_IDX_W;

	logic [qopg_pkg::REG_IDX_W-1:0]    reg_idx;
	logic [qopg_pkg::CORNER_IDX_W-1:0] cidx;
	logic                              wr_en;
	logic                              rd_setup;
	logic                              corner_sel;

	logic [CORNER_W-1:0]               corner_mem [qopg_pkg::CORNER_NUM];
	logic [qopg_pkg::CORNER_NUM-1:0]   corner_vld_q;
	logic [CORNER_W-1:0]               corner_rd_s1;
	logic [qopg_pkg::COLOR_W-1:0]      color_q;
	logic [COUNT_WIDTH-1:0]            dwell_q;
	logic [COUNT_WIDTH-1:0]            edge_q;
	logic [DATA_W-1:0]                 prdata_q;

	// address decode
	assign reg_idx    = paddr[ADDR_W-1:ALIGN];
	assign cidx       = reg_idx[qopg_pkg::CORNER_IDX_W-1:0];
	assign wr_en      = psel && penable && pwrite;
	assign rd_setup   = psel && !penable && !pwrite;
	assign corner_sel = (reg_idx <= qopg_pkg::REG_CORNER_FOUR);
	assign pready     = 1'b1;

	// corner memory write
	always_ff @(posedge clk) begin
		if (wr_en && corner_sel) begin
			corner_mem[cidx] <= pwdata[CORNER_W-1:0];
		end
	end

	// corner valid bits, an unwritten corner reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_vld_q <= '0;
		end else if (wr_en && corner_sel) begin
			corner_vld_q[cidx] <= 1'b1;
		end
	end

	// sequencer read port
	always_ff @(posedge clk) begin
		corner_rd_s1 <= corner_vld_q[rd_addr] ? corner_mem[rd_addr] : '0;
	end

	// color and count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= qopg_pkg::COLOR_RESET;
			dwell_q <= COUNT_WIDTH'(qopg_pkg::DWELL_RESET);
			edge_q  <= COUNT_WIDTH'(qopg_pkg::EDGE_RESET);
		end else if (wr_en) begin
			unique case (qopg_pkg::reg_idx_t'(reg_idx))
				qopg_pkg::REG_POINT_COLOR: color_q <= pwdata[qopg_pkg::COLOR_W-1:0];
				qopg_pkg::REG_DWELL_COUNT: dwell_q <= pwdata[COUNT_WIDTH-1:0];
				qopg_pkg::REG_EDGE_COUNT:  edge_q  <= pwdata[COUNT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// bus read data, captured in the setup cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prdata_q <= '0;
		end else if (rd_setup) begin
			unique case (qopg_pkg::reg_idx_t'(reg_idx))
				qopg_pkg::REG_CORNER_ONE,
				qopg_pkg::REG_CORNER_TWO,
				qopg_pkg::REG_CORNER_THREE,
				qopg_pkg::REG_CORNER_FOUR:
					prdata_q <= DATA_W'(corner_vld_q[cidx] ? corner_mem[cidx] : '0);
				qopg_pkg::REG_POINT_COLOR: prdata_q <= DATA_W'(color_q);
				qopg_pkg::REG_DWELL_COUNT: prdata_q <= DATA_W'(dwell_q);
				qopg_pkg::REG_EDGE_COUNT:  prdata_q <= DATA_W'(edge_q);
				default:                   prdata_q <= '0;
			endcase
		end
	end

	assign prdata      = prdata_q;
	assign corner_rd   = corner_rd_s1;
	assign point_color = color_q;
	assign dwell_count = dwell_q;
	assign edge_count  = edge_q;

endmodule

// ===== sv/qopg_mdu.sv =====
// ----------------------------------------------------------------------------
// Outline point generator multiply/divide unit
// Computes trunc((s*(n-i) + e*i) / n) for one coordinate: two products on
// one multiplier, then a restoring divide at one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qopg_mdu #(
	parameter int COORD_WIDTH = 16,
	parameter int COUNT_WIDTH = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [COORD_WIDTH-1:0] s,
	input  logic signed [COORD_WIDTH-1:0] e,
	input  logic [COUNT_WIDTH-1:0]        i,
	input  logic [COUNT_WIDTH-1:0]        n,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] quot
);

	localparam int PROD_W = COORD_WIDTH + COUNT_WIDTH + 1;
	localparam int ACC_W  = COORD_WIDTH + COUNT_WIDTH + 2;
	localparam int DCNT_W = $clog2(COORD_WIDTH);
	localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(COORD_WIDTH - 1);

	qopg_pkg::mdu_state_t state_q, state_d;

	logic signed [COORD_WIDTH-1:0] s_q;
	logic signed [COORD_WIDTH-1:0] e_q;
	logic [COUNT_WIDTH-1:0]        i_q;
	logic [COUNT_WIDTH-1:0]        n_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic                          neg_q;
	logic [COUNT_WIDTH-1:0]        rem_q;
	logic [COORD_WIDTH-1:0]        quo_q;
	logic [DCNT_W-1:0]             cnt_q;
	logic                          done_q;

	logic signed [COORD_WIDTH-1:0] mul_a;
	logic [COUNT_WIDTH-1:0]        mul_b;
	logic signed [PROD_W-1:0]      prod;
	logic [ACC_W-1:0]              mag;
	logic [COUNT_WIDTH:0]          trial;
	logic                          q_bit;
	logic [COUNT_WIDTH:0]          rem_nx;
	logic                          div_end;

	// shared multiplier: start weight first, end weight second
	assign mul_a = (state_q == qopg_pkg::MDU_MUL_S) ? s_q : e_q;
	assign mul_b = (state_q == qopg_pkg::MDU_MUL_S) ? (n_q - i_q) : i_q;
	assign prod  = mul_a * $signed({1'b0, mul_b});

	// magnitude of the numerator
	assign mag = acc_q[ACC_W-1] ? (~acc_q + 1'b1) : acc_q;

	// restoring divide step
	assign trial   = {rem_q, quo_q[COORD_WIDTH-1]};
	assign q_bit   = (trial >= {1'b0, n_q});
	assign rem_nx  = q_bit ? (trial - {1'b0, n_q}) : trial;
	assign div_end = (state_q == qopg_pkg::MDU_DIV) && (cnt_q == DIV_LAST);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qopg_pkg::MDU_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qopg_pkg::MDU_IDLE:  if (start) state_d = qopg_pkg::MDU_MUL_S;
			qopg_pkg::MDU_MUL_S: state_d = qopg_pkg::MDU_MUL_E;
			qopg_pkg::MDU_MUL_E: state_d = qopg_pkg::MDU_ABS;
			qopg_pkg::MDU_ABS:   state_d = qopg_pkg::MDU_DIV;
			qopg_pkg::MDU_DIV:   if (div_end) state_d = qopg_pkg::MDU_IDLE;
			default:             state_d = qopg_pkg::MDU_IDLE;
		endcase
	end

	// done pulse and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= div_end;
			if (state_q == qopg_pkg::MDU_ABS) begin
				cnt_q <= '0;
			end else if (state_q == qopg_pkg::MDU_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			qopg_pkg::MDU_IDLE: begin
				if (start) begin
					s_q <= s;
					e_q <= e;
					i_q <= i;
					n_q <= n;
				end
			end
			qopg_pkg::MDU_MUL_S: acc_q <= ACC_W'(prod);
			qopg_pkg::MDU_MUL_E: acc_q <= acc_q + ACC_W'(prod);
			qopg_pkg::MDU_ABS: begin
				neg_q <= acc_q[ACC_W-1];
				rem_q <= mag[COORD_WIDTH +: COUNT_WIDTH];
				quo_q <= mag[COORD_WIDTH-1:0];
			end
			qopg_pkg::MDU_DIV: begin
				rem_q <= rem_nx[COUNT_WIDTH-1:0];
				quo_q <= {quo_q[COORD_WIDTH-2:0], q_bit};
			end
			default: ;
		endcase
	end

	// signed result, valid while done is high
	assign quot = neg_q ? $signed(~quo_q + 1'b1) : $signed(quo_q);
	assign done = done_q;

endmodule

// ===== sv/qopg_seq.sv =====
// ----------------------------------------------------------------------------
// Outline point generator sequencer
// Tracks corner, phase and step, fetches corners, drives the shared
// multiply/divide unit and loads the point output register.
// ----------------------------------------------------------------------------
module qopg_seq #(
	parameter int COORD_WIDTH = 16,
	parameter int COUNT_WIDTH = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	qopg_req_if.sink                           req,
	qopg_point_if.source                       point,
	input  logic [qopg_pkg::COLOR_W-1:0]       point_color,
	input  logic [COUNT_WIDTH-1:0]             dwell_count,
	input  logic [COUNT_WIDTH-1:0]             edge_count,
	output logic [qopg_pkg::CORNER_IDX_W-1:0]  rd_addr,
	input  logic [2*COORD_WIDTH-1:0]           corner_rd,
	output logic                               mdu_start,
	output logic signed [COORD_WIDTH-1:0]      mdu_s,
	output logic signed [COORD_WIDTH-1:0]      mdu_e,
	output logic [COUNT_WIDTH-1:0]             mdu_i,
	output logic [COUNT_WIDTH-1:0]             mdu_n,
	input  logic                               mdu_done,
	input  logic signed [COORD_WIDTH-1:0]      mdu_quot
);

	qopg_pkg::seq_state_t state_q, state_d;

	logic [qopg_pkg::CORNER_IDX_W-1:0] ci_q;
	logic                              ph_q;
	logic [COUNT_WIDTH-1:0]            step_q;
	logic [2*COORD_WIDTH-1:0]          start_q;
	logic signed [COORD_WIDTH-1:0]     end_y_q;
	logic signed [COORD_WIDTH-1:0]     px_q;
	logic signed [COORD_WIDTH-1:0]     py_q;
	logic                              out_valid_q;
	logic signed [COORD_WIDTH-1:0]     out_x_q;
	logic signed [COORD_WIDTH-1:0]     out_y_q;
	logic [qopg_pkg::COLOR_W-1:0]      out_color_q;
	logic                              out_end_q;

	logic                              both_zero;
	logic                              skip_dwell;
	logic                              skip_edge;
	logic [COUNT_WIDTH:0]              step_inc;
	logic                              last;
	logic                              out_load;

	// phase bookkeeping
	assign both_zero  = (dwell_count == '0) && (edge_count == '0);
	assign skip_dwell = !ph_q && (step_q >= dwell_count);
	assign skip_edge  = ph_q && (step_q >= edge_count);
	assign step_inc   = {1'b0, step_q} + 1'b1;
	assign last       = (ci_q == qopg_pkg::LAST_CORNER) &&
		(ph_q ? (step_inc >= {1'b0, edge_count})
		      : ((step_inc >= {1'b0, dwell_count}) && (edge_count == '0)));
	assign out_load   = (state_q == qopg_pkg::SEQ_EMIT) && (!out_valid_q || point.ready);

	assign mdu_i = step_q;
	assign mdu_n = edge_count;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qopg_pkg::SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and unit control
	always_comb begin
		state_d   = state_q;
		mdu_start = 1'b0;
		rd_addr   = ci_q;
		mdu_s     = $signed(start_q[COORD_WIDTH-1:0]);
		mdu_e     = end_y_q;
		unique case (state_q)
			qopg_pkg::SEQ_IDLE: begin
				if (req.valid) state_d = qopg_pkg::SEQ_SKIP;
			end
			qopg_pkg::SEQ_SKIP: begin
				if (both_zero) begin
					state_d = qopg_pkg::SEQ_IDLE;
				end else if (!skip_dwell && !skip_edge) begin
					state_d = qopg_pkg::SEQ_FETCH_S;
				end
			end
			qopg_pkg::SEQ_FETCH_S: state_d = qopg_pkg::SEQ_FETCH_E;
			qopg_pkg::SEQ_FETCH_E: begin
				rd_addr = ci_q + 1'b1;
				state_d = ph_q ? qopg_pkg::SEQ_START_X : qopg_pkg::SEQ_EMIT;
			end
			qopg_pkg::SEQ_START_X: begin
				mdu_start = 1'b1;
				mdu_s     = $signed(start_q[2*COORD_WIDTH-1:COORD_WIDTH]);
				mdu_e     = $signed(corner_rd[2*COORD_WIDTH-1:COORD_WIDTH]);
				state_d   = qopg_pkg::SEQ_WAIT_X;
			end
			qopg_pkg::SEQ_WAIT_X: begin
				if (mdu_done) begin
					mdu_start = 1'b1;
					state_d   = qopg_pkg::SEQ_WAIT_Y;
				end
			end
			qopg_pkg::SEQ_WAIT_Y: begin
				if (mdu_done) state_d = qopg_pkg::SEQ_EMIT;
			end
			qopg_pkg::SEQ_EMIT: begin
				if (out_load) state_d = qopg_pkg::SEQ_IDLE;
			end
			default: state_d = qopg_pkg::SEQ_IDLE;
		endcase
	end

	// outline position and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_q        <= '0;
			ph_q        <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == qopg_pkg::SEQ_IDLE && req.valid && req.restart) begin
				ci_q   <= '0;
				ph_q   <= 1'b0;
				step_q <= '0;
			end
			// one finished or empty phase skipped per cycle
			if (state_q == qopg_pkg::SEQ_SKIP && !both_zero) begin
				if (skip_dwell) begin
					ph_q   <= 1'b1;
					step_q <= '0;
				end else if (skip_edge) begin
					ph_q   <= 1'b0;
					step_q <= '0;
					ci_q   <= ci_q + 1'b1;
				end
			end
			if (out_load) begin
				step_q      <= step_inc[COUNT_WIDTH-1:0];
				out_valid_q <= 1'b1;
			end else if (point.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// corner capture, coordinate results and output payload
	always_ff @(posedge clk) begin
		if (state_q == qopg_pkg::SEQ_FETCH_E) begin
			start_q <= corner_rd;
			px_q    <= $signed(corner_rd[2*COORD_WIDTH-1:COORD_WIDTH]);
			py_q    <= $signed(corner_rd[COORD_WIDTH-1:0]);
		end
		if (state_q == qopg_pkg::SEQ_START_X) begin
			end_y_q <= $signed(corner_rd[COORD_WIDTH-1:0]);
		end
		if (state_q == qopg_pkg::SEQ_WAIT_X && mdu_done) begin
			px_q <= mdu_quot;
		end
		if (state_q == qopg_pkg::SEQ_WAIT_Y && mdu_done) begin
			py_q <= mdu_quot;
		end
		if (out_load) begin
			out_x_q     <= px_q;
			out_y_q     <= py_q;
			out_color_q <= point_color;
			out_end_q   <= last;
		end
	end

	assign req.ready         = (state_q == qopg_pkg::SEQ_IDLE);
	assign point.valid       = out_valid_q;
	assign point.point_x     = out_x_q;
	assign point.point_y     = out_y_q;
	assign point.out_color   = out_color_q;
	assign point.outline_end = out_end_q;

endmodule

// ===== sv/quad_outline_point_generator_top.sv =====
// ----------------------------------------------------------------------------
// Quad outline point generator
// Traces a closed four-corner outline, one point per request unless both counts are zero.
// ----------------------------------------------------------------------------
// Each request returns the next point of the outline: every corner is repeated
// dwell_count times, then edge_count points run from it toward the next
// corner (corner four leads back to corner one); edge point i is
// start - (start - end) * i / edge_count truncated toward zero. The last point
// of the outline carries outline_end, and restart rewinds to the first dwell
// point of corner one before producing its point. With both counts zero a
// request is taken and returns nothing. Requests are taken one at a time:
// ready is high only while the sequencer is idle, and the result sits in an
// output register so a new request can be taken while it waits. A dwell point
// is loaded after the skip state and the two corner fetch states; an edge
// point also waits for the shared multiply/divide unit, which forms the
// numerator in two multiplier passes and then divides at one quotient bit per
// cycle, first for x and then for y. The next request can be taken in the
// cycle after the point is loaded. Each finished or empty phase on the way is
// passed over in the skip state. Setup registers must be written over APB only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module quad_outline_point_generator_top #(
	parameter  int COORD_WIDTH = 16,
	parameter  int COUNT_WIDTH = 10,
	localparam int DATA_W      = (2 * COORD_WIDTH > 32) ? 64 : 32,
	localparam int ADDR_W      = ((DATA_W > 32) ? 3 : 2) + qopg_pkg::REG_IDX_W
) (
	input  logic              clk,
	input  logic              arst_n,
	qopg_req_if.sink          req,
	qopg_point_if.source      point,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [qopg_pkg::CORNER_IDX_W-1:0] rd_addr;
	logic [2*COORD_WIDTH-1:0]          corner_rd;
	logic [qopg_pkg::COLOR_W-1:0]      point_color;
	logic [COUNT_WIDTH-1:0]            dwell_count;
	logic [COUNT_WIDTH-1:0]            edge_count;
	logic                              mdu_start;
	logic signed [COORD_WIDTH-1:0]     mdu_s;
	logic signed [COORD_WIDTH-1:0]     mdu_e;
	logic [COUNT_WIDTH-1:0]            mdu_i;
	logic [COUNT_WIDTH-1:0]            mdu_n;
	logic                              mdu_done;
	logic signed [COORD_WIDTH-1:0]     mdu_quot;

	// setup registers and corner memory
	qopg_regs #(
		.COORD_WIDTH (COORD_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH),
		.DATA_W      (DATA_W),
		.ADDR_W      (ADDR_W)
	) u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.rd_addr     (rd_addr),
		.corner_rd   (corner_rd),
		.point_color (point_color),
		.dwell_count (dwell_count),
		.edge_count  (edge_count)
	);

	// sequencer
	qopg_seq #(
		.COORD_WIDTH (COORD_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.point       (point),
		.point_color (point_color),
		.dwell_count (dwell_count),
		.edge_count  (edge_count),
		.rd_addr     (rd_addr),
		.corner_rd   (corner_rd),
		.mdu_start   (mdu_start),
		.mdu_s       (mdu_s),
		.mdu_e       (mdu_e),
		.mdu_i       (mdu_i),
		.mdu_n       (mdu_n),
		.mdu_done    (mdu_done),
		.mdu_quot    (mdu_quot)
	);

	// shared multiply/divide unit
	qopg_mdu #(
		.COORD_WIDTH (COORD_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mdu_start),
		.s      (mdu_s),
		.e      (mdu_e),
		.i      (mdu_i),
		.n      (mdu_n),
		.done   (mdu_done),
		.quot   (mdu_quot)
	);

endmodule

// ===== sv/qopg_checker.sv =====
// ----------------------------------------------------------------------------
// Outline point generator port checker
// Watches the request and point channels of the top level.
// ----------------------------------------------------------------------------
`include "quad_outline_point_generator_top_defines.svh"

module qopg_checker #(
	parameter int COORD_WIDTH = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          point_valid,
	input logic                          point_ready,
	input logic signed [COORD_WIDTH-1:0] point_x,
	input logic signed [COORD_WIDTH-1:0] point_y,
	input logic [qopg_pkg::COLOR_W-1:0]  out_color,
	input logic                          outline_end
);

	// one request at a time: busy right after a transaction
	`QOPG_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready,
		"request taken while previous one still in work")

	// a new point is loaded only while the sequencer is busy
	`QOPG_ASSERT_SAME(a_point_from_busy, clk, arst_n, $rose(point_valid), $past(!req_ready),
		"point appeared without a request in work")

	// stalled point stays offered
	`QOPG_ASSERT_NEXT(a_point_hold, clk, arst_n, point_valid && !point_ready, point_valid,
		"stalled point dropped")

	// stalled point keeps its payload
	`QOPG_ASSERT_NEXT(a_point_stable, clk, arst_n, point_valid && !point_ready,
		$stable(point_x) && $stable(point_y) && $stable(out_color) && $stable(outline_end),
		"stalled point changed")

endmodule

bind quad_outline_point_generator_top qopg_checker #(
	.COORD_WIDTH (COORD_WIDTH)
) u_qopg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.point_valid (point.valid),
	.point_ready (point.ready),
	.point_x     (point.point_x),
	.point_y     (point.point_y),
	.out_color   (point.out_color),
	.outline_end (point.outline_end)
);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Quad outline point generator testbench
// Drives outline point requests and APB setup writes into the generator,
// predicts every point (corner dwell, edge interpolation, outline end flag,
// restart and skipped phases) and compares each returned point in order.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW           = 16;
	localparam int NW           = 10;
	localparam int ITEM_TARGET  = 1950;
	localparam int CALM_AFTER   = 1700;
	localparam int SETTLE_CYCLES = 80;

	typedef struct packed {
		logic signed [CW-1:0]          x;
		logic signed [CW-1:0]          y;
		logic [qopg_pkg::COLOR_W-1:0]  color;
		logic                          is_last;
	} outline_point_t;

	// Scoreboard: own copy of the setup registers and the outline position
	class outline_scoreboard;
		logic [2*CW-1:0]               corner [qopg_pkg::CORNER_NUM];
		logic [qopg_pkg::COLOR_W-1:0]  color;
		logic [NW-1:0]                 dwell_len;
		logic [NW-1:0]                 edge_len;
		logic [1:0]                    corner_idx;
		bit                            on_edge;
		logic [NW:0]                   step;
		outline_point_t                expected_points [$];
		int                            errors;

		function new();
			foreach (corner[k])
				corner[k] = '0;
			color      = qopg_pkg::COLOR_RESET;
			dwell_len  = NW'(qopg_pkg::DWELL_RESET);
			edge_len   = NW'(qopg_pkg::EDGE_RESET);
			corner_idx = '0;
			on_edge    = 1'b0;
			step       = '0;
			errors     = 0;
		endfunction

		function void write_reg(qopg_pkg::reg_idx_t idx, logic [31:0] value);
			unique case (idx)
				qopg_pkg::REG_CORNER_ONE, qopg_pkg::REG_CORNER_TWO,
				qopg_pkg::REG_CORNER_THREE, qopg_pkg::REG_CORNER_FOUR: begin
					corner[int'(idx)] = value[2*CW-1:0];
				end
				qopg_pkg::REG_POINT_COLOR: begin
					color = value[qopg_pkg::COLOR_W-1:0];
				end
				qopg_pkg::REG_DWELL_COUNT: begin
					dwell_len = value[NW-1:0];
				end
				qopg_pkg::REG_EDGE_COUNT: begin
					edge_len = value[NW-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function longint coord(int c, bit want_x);
			logic [2*CW-1:0] r;
			r = corner[c & 3];
			return want_x ? longint'($signed(r[2*CW-1:CW])) : longint'($signed(r[CW-1:0]));
		endfunction

		// S - (S - E) * i / n, truncated toward zero
		function longint lerp_coord(longint s, longint e, longint i, longint n);
			return (s * n - (s - e) * i) / n;
		endfunction

		// Advance the outline by one request and queue the point it yields
		function void note_request(logic restart);
			outline_point_t p;
			int nxt;
			if (restart) begin
				corner_idx = '0;
				on_edge    = 1'b0;
				step       = '0;
			end
			if (dwell_len == 0 && edge_len == 0)
				return;
			// pass over finished or empty phases
			for (int k = 0; k < 10; k++) begin
				if (!on_edge && step >= dwell_len) begin
					on_edge = 1'b1;
					step    = '0;
				end else if (on_edge && step >= edge_len) begin
					on_edge    = 1'b0;
					step       = '0;
					corner_idx = corner_idx + 2'd1;
				end else begin
					break;
				end
			end
			p.color = color;
			if (!on_edge) begin
				p.x       = CW'(coord(corner_idx, 1'b1));
				p.y       = CW'(coord(corner_idx, 1'b0));
				p.is_last = corner_idx == qopg_pkg::LAST_CORNER
					&& int'(step) + 1 >= int'(dwell_len) && edge_len == 0;
			end else begin
				nxt       = (int'(corner_idx) + 1) & 3;
				p.x       = CW'(lerp_coord(coord(corner_idx, 1'b1), coord(nxt, 1'b1),
					longint'(step), longint'(edge_len)));
				p.y       = CW'(lerp_coord(coord(corner_idx, 1'b0), coord(nxt, 1'b0),
					longint'(step), longint'(edge_len)));
				p.is_last = corner_idx == qopg_pkg::LAST_CORNER
					&& int'(step) + 1 >= int'(edge_len);
			end
			step = step + 1'b1;
			expected_points.insert(expected_points.size(), p);
		endfunction

		function void check_point(outline_point_t got);
			outline_point_t want;
			if (expected_points.size() == 0) begin
				errors++;
				$display("%0t unexpected point: expected none, actual x=%0d y=%0d color=%h end=%b",
					$time, got.x, got.y, got.color, got.is_last);
				return;
			end
			want = expected_points.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t point mismatch: expected x=%0d y=%0d color=%h end=%b,",
					$time, want.x, want.y, want.color, want.is_last,
					" actual x=%0d y=%0d color=%h end=%b",
					got.x, got.y, got.color, got.is_last);
			end
		endfunction

		function int pending();
			return expected_points.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	bit          calm;

	qopg_req_if                        req_ch ();
	qopg_point_if #(.COORD_WIDTH(CW))  pt_ch ();

	outline_scoreboard board = new();

	quad_outline_point_generator_top #(
		.COORD_WIDTH(CW),
		.COUNT_WIDTH(NW)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.point   (pt_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit
	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Monitor: setup writes, accepted requests, accepted points
	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready)
				board.write_reg(qopg_pkg::reg_idx_t'(paddr[4:2]), pwdata);
			if (req_ch.valid && req_ch.ready)
				board.note_request(req_ch.restart);
			if (pt_ch.valid && pt_ch.ready)
				board.check_point({pt_ch.point_x, pt_ch.point_y, pt_ch.out_color,
					pt_ch.outline_end});
		end
	end

	// Point sink back-pressure: stall bursts between free-running stretches
	initial begin
		pt_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 2) == 0) begin
				pt_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				pt_ch.ready <= 1'b1;
			end else begin
				pt_ch.ready <= 1'b1;
				repeat ($urandom_range(0, 29)) @(negedge clk);
			end
		end
	end

	// APB write: setup cycle, then access cycle until pready
	task automatic apb_write(qopg_pkg::reg_idx_t idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic program_outline(logic [31:0] c1, logic [31:0] c2, logic [31:0] c3,
		logic [31:0] c4, logic [23:0] color, logic [9:0] dwell, logic [9:0] edges);
		apb_write(qopg_pkg::REG_CORNER_ONE, c1);
		apb_write(qopg_pkg::REG_CORNER_TWO, c2);
		apb_write(qopg_pkg::REG_CORNER_THREE, c3);
		apb_write(qopg_pkg::REG_CORNER_FOUR, c4);
		apb_write(qopg_pkg::REG_POINT_COLOR, {8'h00, color});
		apb_write(qopg_pkg::REG_DWELL_COUNT, {22'd0, dwell});
		apb_write(qopg_pkg::REG_EDGE_COUNT, {22'd0, edges});
	endtask

	// Holds valid high until the transaction is taken; returns at a falling edge
	task automatic send_request(logic restart);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.restart <= restart;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// Idle point: every expected point back, plus time for a request with no point
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [15:0] pick_coord();
		unique case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [9:0] pick_count();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 10'd0;
		if (r == 1)
			return 10'd1023;
		if (r == 2)
			return 10'($urandom_range(0, 1023));
		return 10'($urandom_range(1, 6));
	endfunction

	function automatic logic [23:0] pick_color();
		unique case ($urandom_range(0, 4))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			default: return 24'($urandom);
		endcase
	endfunction

	initial begin
		int sent;
		int n_items;
		logic [9:0] dwell;
		logic [9:0] edges;

		arst_n         = 1'b0;
		calm           = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.restart = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		sent           = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Extreme corners, short outline that wraps once
		program_outline({16'h7FFF, 16'h8000}, {16'h8000, 16'h7FFF}, {16'h7FFF, 16'h7FFF},
			{16'h8000, 16'h8000}, 24'h000000, 10'd1, 10'd2);
		repeat (13) send_request(1'b0);
		drain();

		// Both counts zero: requests taken, no points
		apb_write(qopg_pkg::REG_POINT_COLOR, 32'h00FF_FFFF);
		apb_write(qopg_pkg::REG_DWELL_COUNT, 32'd0);
		apb_write(qopg_pkg::REG_EDGE_COUNT, 32'd0);
		send_request(1'b1);
		send_request(1'b0);
		drain();

		// No dwell phase at all
		apb_write(qopg_pkg::REG_EDGE_COUNT, 32'd1);
		send_request(1'b1);
		repeat (4) send_request(1'b0);
		drain();

		// No edge phase, restart in the middle of the outline
		apb_write(qopg_pkg::REG_DWELL_COUNT, 32'd2);
		apb_write(qopg_pkg::REG_EDGE_COUNT, 32'd0);
		repeat (3) send_request(1'b0);
		send_request(1'b1);
		send_request(1'b0);
		drain();

		// Random outlines; position carries over so counts change mid-outline
		while (sent < ITEM_TARGET) begin
			dwell = pick_count();
			edges = pick_count();
			program_outline({pick_coord(), pick_coord()}, {pick_coord(), pick_coord()},
				{pick_coord(), pick_coord()}, {pick_coord(), pick_coord()},
				pick_color(), dwell, edges);
			if (dwell == 0 && edges == 0)
				n_items = 3;
			else if (dwell > 100 || edges > 100)
				n_items = $urandom_range(20, 60);
			else
				n_items = $urandom_range(30, 120);
			for (int k = 0; k < n_items; k++)
				send_request($urandom_range(0, 15) == 0);
			if (dwell != 0 || edges != 0)
				sent += n_items;
			if (sent >= CALM_AFTER)
				calm = 1'b1;
			drain();
		end

		if (board.errors == 0 && board.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
